// ===== hw/rtl/pmu_pkg.sv =====
`timescale 1ns / 1ps

package pmu_pkg;

    localparam int POS_W      = 24;
    localparam int LIFE_W     = 16;
    localparam int MAXL_W     = 15;
    localparam int Q16_W      = 16;
    localparam int GRAV_W     = 18;
    localparam int CFG_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int LAT        = 10;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_PER_ST = 2;
    localparam int DIV_ST     = DIV_STEPS / DIV_PER_ST;

    localparam int SINE_DEPTH = 256;
    localparam int IDX_W      = $clog2(SINE_DEPTH);

    localparam logic [63:0] TWO_PI_Q20  = 64'd6588397;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam int MAG_W     = 31;
    localparam int RCP_SHIFT = 40;
    localparam logic [31:0] RECIP =
        32'(((64'd1 << RCP_SHIFT) * 64'(SINE_DEPTH)) / TWO_PI_Q20);
    localparam int QUO_W = 24;
    localparam int REM_W = 48;

    localparam logic [GRAV_W-1:0] GRAVITY_RST = 18'd40182;
    localparam logic [Q16_W-1:0]  DRAG_RST    = 16'd64881;
    localparam logic [Q16_W-1:0]  RATE_RST    = 16'd2560;
    localparam logic [Q16_W-1:0]  DEPTH_RST   = 16'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY = 2'd0,
        REG_DRAG    = 2'd1,
        REG_RATE    = 2'd2,
        REG_DEPTH   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [GRAV_W-1:0] gravity;
        logic [Q16_W-1:0]  drag_factor;
        logic [Q16_W-1:0]  pulse_rate;
        logic [Q16_W-1:0]  pulse_depth;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x_in;
        logic signed [POS_W-1:0]  pos_y_in;
        logic signed [POS_W-1:0]  pos_z_in;
        logic signed [POS_W-1:0]  vel_x_in;
        logic signed [POS_W-1:0]  vel_y_in;
        logic signed [POS_W-1:0]  vel_z_in;
        logic signed [LIFE_W-1:0] life_in;
        logic [MAXL_W-1:0]        max_life;
        logic [Q16_W-1:0]         alpha_in;
        logic [Q16_W-1:0]         size_in;
        logic [Q16_W-1:0]         time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x_out;
        logic signed [POS_W-1:0]  pos_y_out;
        logic signed [POS_W-1:0]  pos_z_out;
        logic signed [POS_W-1:0]  vel_x_out;
        logic signed [POS_W-1:0]  vel_y_out;
        logic signed [POS_W-1:0]  vel_z_out;
        logic signed [LIFE_W-1:0] life_out;
        logic [Q16_W-1:0]         alpha_out;
        logic [Q16_W-1:0]         size_out;
        logic                     alive;
    } t_out_item;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pos;
        logic [2:0][POS_W-1:0] vel;
    } t_kin_res;

    typedef struct packed {
        logic                     alive;
        logic                     big;
        logic signed [LIFE_W-1:0] life;
        logic [Q16_W-1:0]         alpha;
    } t_div_ctl;

    typedef logic signed [15:0] t_sine_rom [SINE_DEPTH];

    function automatic logic signed [LIFE_W-1:0] life_next(
        input logic signed [LIFE_W-1:0] life,
        input logic [Q16_W-1:0]         dt
    );
        logic [16:0]        dr;
        logic signed [17:0] diff;
        dr   = ({1'b0, dt} + 17'd8) >> 4;
        diff = 18'(life) - $signed({1'b0, dr});
        if (diff < -18'sd32768) begin
            return 16'sh8000;
        end
        return diff[LIFE_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [47:0] x);
        if (x > 48'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (x < -48'sd8388608) begin
            return 24'sh800000;
        end
        return x[POS_W-1:0];
    endfunction

    function automatic logic [63:0] term_div(
        input logic [63:0] t,
        input int          k,
        input logic        odd
    );
        logic [63:0] res;
        res = t;
        case (k)
            1:  res = odd ? t / 6   : t / 2;
            2:  res = odd ? t / 20  : t / 12;
            3:  res = odd ? t / 42  : t / 30;
            4:  res = odd ? t / 72  : t / 56;
            5:  res = odd ? t / 110 : t / 90;
            6:  res = odd ? t / 156 : t / 132;
            7:  res = odd ? t / 210 : t / 182;
            8:  res = odd ? t / 272 : t / 240;
            9:  res = odd ? t / 342 : t / 306;
            10: res = odd ? t / 420 : t / 380;
            default: res = t;
        endcase
        return res;
    endfunction

    function automatic logic [63:0] sine_series(input logic [63:0] x, input logic odd);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        x2   = (x * x) >> 30;
        term = odd ? x : (64'd1 << 30);
        pos  = term;
        neg  = 64'd0;
        for (int k = 1; k <= 10; k++) begin
            term = term_div((term * x2) >> 30, k, odd);
            if ((k % 2) == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    function automatic t_sine_rom sine_build();
        t_sine_rom   rom;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] v;
        logic [63:0] s;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            q = 64'(4 * i) / 64'(SINE_DEPTH);
            r = 64'(4 * i) - q * 64'(SINE_DEPTH);
            x = (r * HALF_PI_Q30) / 64'(SINE_DEPTH);
            v = sine_series(x, q[0] == 1'b0);
            s = (v + (64'd1 << 14)) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            rom[i] = (q >= 64'd2) ? -$signed(s[15:0]) : $signed(s[15:0]);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = sine_build();

endpackage

// ===== hw/rtl/pmu_kin.sv =====
`timescale 1ns / 1ps

module pmu_kin (
    input  logic              i_clk,
    input  logic              i_en,
    input  pmu_pkg::t_in_item i_item,
    input  pmu_pkg::t_cfg     i_cfg,
    output pmu_pkg::t_kin_res o_res
);

    localparam int KIN_DLY = pmu_pkg::LAT - 4;

    logic signed [pmu_pkg::POS_W-1:0] w_p [3];
    logic signed [pmu_pkg::POS_W-1:0] w_v [3];

    logic signed [40:0] r1_pv [3];
    logic signed [pmu_pkg::POS_W-1:0] r1_p [3];
    logic signed [pmu_pkg::POS_W-1:0] r1_v [3];
    logic [33:0] r1_gdt;

    logic signed [pmu_pkg::POS_W-1:0] r2_np [3];
    logic signed [25:0] r2_v [3];
    logic signed [pmu_pkg::POS_W-1:0] r3_np [3];
    logic signed [42:0] r3_vd [3];

    pmu_pkg::t_kin_res r4_res;
    pmu_pkg::t_kin_res r_dly [KIN_DLY];

    logic signed [pmu_pkg::POS_W-1:0] n2_np [3];
    logic signed [25:0] n2_v [3];
    logic [18:0] n2_g;
    pmu_pkg::t_kin_res n4_res;

    assign w_p[0] = i_item.pos_x_in;
    assign w_p[1] = i_item.pos_y_in;
    assign w_p[2] = i_item.pos_z_in;
    assign w_v[0] = i_item.vel_x_in;
    assign w_v[1] = i_item.vel_y_in;
    assign w_v[2] = i_item.vel_z_in;

    always_comb begin
        n2_g = 19'((35'(r1_gdt) + 35'd32768) >> 16);
        for (int j = 0; j < 3; j++) begin
            n2_np[j] = pmu_pkg::sat_pos(48'(r1_p[j]) + 48'((r1_pv[j] + 41'sd32768) >>> 16));
            n2_v[j]  = (j == 1) ? 26'(r1_v[j]) - $signed({7'd0, n2_g}) : 26'(r1_v[j]);
        end
        for (int j = 0; j < 3; j++) begin
            n4_res.pos[j] = r3_np[j];
            n4_res.vel[j] = pmu_pkg::sat_pos(48'((44'(r3_vd[j]) + 44'sd32768) >>> 16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r1_pv[j] <= w_v[j] * $signed({1'b0, i_item.time_step});
                r1_p[j]  <= w_p[j];
                r1_v[j]  <= w_v[j];
                r2_np[j] <= n2_np[j];
                r2_v[j]  <= n2_v[j];
                r3_np[j] <= r2_np[j];
                r3_vd[j] <= r2_v[j] * $signed({1'b0, i_cfg.drag_factor});
            end
            r1_gdt <= i_cfg.gravity * i_item.time_step;
            r4_res <= n4_res;
            r_dly[0] <= r4_res;
            for (int k = 1; k < KIN_DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign o_res = r_dly[KIN_DLY-1];

endmodule

// ===== hw/rtl/pmu_div.sv =====
`timescale 1ns / 1ps

module pmu_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  pmu_pkg::t_in_item                  i_item,
    output logic signed [pmu_pkg::LIFE_W-1:0]  o_life,
    output logic [pmu_pkg::Q16_W-1:0]          o_alpha,
    output logic                               o_alive
);

    localparam int NST = pmu_pkg::DIV_ST;

    logic signed [pmu_pkg::LIFE_W-1:0] w_life;
    pmu_pkg::t_div_ctl n0_ctl;

    logic [15:0] r_rem [NST+1];
    logic [15:0] r_q   [NST+1];
    logic [15:0] r_ml  [NST+1];
    pmu_pkg::t_div_ctl r_ctl [NST+1];

    logic [15:0] n_rem [NST];
    logic [15:0] n_q   [NST];

    logic signed [pmu_pkg::LIFE_W-1:0] r_life;
    logic [pmu_pkg::Q16_W-1:0]         r_alpha;
    logic                              r_alive;

    always_comb begin
        w_life       = pmu_pkg::life_next(i_item.life_in, i_item.time_step);
        n0_ctl.life  = w_life;
        n0_ctl.alive = w_life > 16'sd0;
        n0_ctl.big   = {1'b0, w_life[14:0]} >= {1'b0, i_item.max_life};
        n0_ctl.alpha = i_item.alpha_in;
    end

    always_comb begin
        logic [15:0] rem;
        logic [15:0] q;
        for (int s = 0; s < NST; s++) begin
            rem = r_rem[s];
            q   = r_q[s];
            for (int b = 0; b < pmu_pkg::DIV_PER_ST; b++) begin
                rem = {rem[14:0], 1'b0};
                q   = {q[14:0], 1'b0};
                if (rem >= r_ml[s]) begin
                    rem  = rem - r_ml[s];
                    q[0] = 1'b1;
                end
            end
            n_rem[s] = rem;
            n_q[s]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, w_life[14:0]};
            r_q[0]   <= 16'd0;
            r_ml[0]  <= {1'b0, i_item.max_life};
            r_ctl[0] <= n0_ctl;
            for (int s = 0; s < NST; s++) begin
                r_rem[s+1] <= n_rem[s];
                r_q[s+1]   <= n_q[s];
                r_ml[s+1]  <= r_ml[s];
                r_ctl[s+1] <= r_ctl[s];
            end
            r_life  <= r_ctl[NST].life;
            r_alive <= r_ctl[NST].alive;
            if (!r_ctl[NST].alive) begin
                r_alpha <= r_ctl[NST].alpha;
            end else if (r_ctl[NST].big) begin
                r_alpha <= 16'hFFFF;
            end else begin
                r_alpha <= r_q[NST];
            end
        end
    end

    assign o_life  = r_life;
    assign o_alpha = r_alpha;
    assign o_alive = r_alive;

endmodule

// ===== hw/rtl/pmu_pulse.sv =====
`timescale 1ns / 1ps

module pmu_pulse (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  pmu_pkg::t_in_item         i_item,
    input  pmu_pkg::t_cfg             i_cfg,
    output logic [pmu_pkg::Q16_W-1:0] o_size
);

    localparam int IW = pmu_pkg::IDX_W;
    localparam int SW = 9;
    localparam int DW = 6;

    logic [pmu_pkg::Q16_W-1:0] r_sz [SW];
    logic [pmu_pkg::Q16_W-1:0] r_dt [DW];

    logic signed [32:0]                  r1_phase;
    logic                                r2_neg;
    logic [pmu_pkg::MAG_W-1:0]           r2_a;
    logic [62:0]                         r2_p;
    logic                                r3_neg;
    logic [pmu_pkg::MAG_W-1:0]           r3_a;
    logic [pmu_pkg::QUO_W-1:0]           r3_q0;
    logic [pmu_pkg::REM_W-1:0]           r3_t;
    logic [IW-1:0]                       r4_idx;
    logic signed [15:0]                  r5_s;
    logic signed [32:0]                  r6_m1p;
    logic signed [34:0]                  r7_m2p;
    logic signed [19:0]                  r8_m2;
    logic signed [36:0]                  r9_sp;
    logic [pmu_pkg::Q16_W-1:0]           r10_size;

    logic [32:0]               n2_mag;
    logic [pmu_pkg::QUO_W-1:0] n3_q0;
    logic [pmu_pkg::REM_W-1:0] n4_rem;
    logic [pmu_pkg::QUO_W-1:0] n4_q;
    logic                      n4_exact;
    logic [pmu_pkg::QUO_W-1:0] n4_sq;
    logic signed [17:0]        n7_m1;
    logic signed [23:0]        n10_sum;

    always_comb begin
        n2_mag   = r1_phase[32] ? 33'(-r1_phase) : 33'(r1_phase);
        n3_q0    = pmu_pkg::QUO_W'(r2_p >> pmu_pkg::RCP_SHIFT);
        n4_rem   = (pmu_pkg::REM_W'(r3_a) << IW) - r3_t;
        n4_q     = r3_q0 + pmu_pkg::QUO_W'(n4_rem >= pmu_pkg::REM_W'(pmu_pkg::TWO_PI_Q20));
        n4_exact = (n4_rem == '0) || (n4_rem == pmu_pkg::REM_W'(pmu_pkg::TWO_PI_Q20));
        n4_sq    = r3_neg ? -(n4_q + pmu_pkg::QUO_W'(!n4_exact)) : n4_q;
        n7_m1    = 18'((34'(r6_m1p) + 34'sd32768) >>> 16);
        n10_sum  = $signed({8'd0, r_sz[8]}) + 24'((38'(r9_sp) + 38'sd16384) >>> 15);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sz[0] <= i_item.size_in;
            r_dt[0] <= i_item.time_step;
            for (int k = 1; k < SW; k++) begin
                r_sz[k] <= r_sz[k-1];
            end
            for (int k = 1; k < DW; k++) begin
                r_dt[k] <= r_dt[k-1];
            end
            r1_phase <= pmu_pkg::life_next(i_item.life_in, i_item.time_step)
                        * $signed({1'b0, i_cfg.pulse_rate});
            r2_neg   <= r1_phase[32];
            r2_a     <= n2_mag[pmu_pkg::MAG_W-1:0];
            r2_p     <= 63'(n2_mag[pmu_pkg::MAG_W-1:0]) * 63'(pmu_pkg::RECIP);
            r3_neg   <= r2_neg;
            r3_a     <= r2_a;
            r3_q0    <= n3_q0;
            r3_t     <= pmu_pkg::REM_W'(n3_q0) * pmu_pkg::REM_W'(pmu_pkg::TWO_PI_Q20);
            r4_idx   <= n4_sq[IW-1:0];
            r5_s     <= pmu_pkg::SINE_ROM[r4_idx];
            r6_m1p   <= r5_s * $signed({1'b0, i_cfg.pulse_depth});
            r7_m2p   <= n7_m1 * $signed({1'b0, r_dt[5]});
            r8_m2    <= 20'((36'(r7_m2p) + 36'sd32768) >>> 16);
            r9_sp    <= $signed({1'b0, r_sz[7]}) * r8_m2;
            if (n10_sum < 24'sd0) begin
                r10_size <= 16'd0;
            end else if (n10_sum > 24'sd65535) begin
                r10_size <= 16'hFFFF;
            end else begin
                r10_size <= n10_sum[15:0];
            end
        end
    end

    assign o_size = r10_size;

endmodule

// ===== hw/rtl/particle_motion_update.sv =====
`timescale 1ns / 1ps

// Advances one particle record by one Euler time step: position, velocity
// with gravity and drag, life, alpha as life over maximum life while alive
// (otherwise the input alpha), and a sine-pulsed size. The block takes one
// word per clock while the output is not stalled, and presents each result
// through ten register stages set by the alpha divider and the size pulse path.
// Backpressure on the output stalls the whole pipeline without losing or
// repeating a word.
// Configuration writes should be made only while the pipeline is empty.

module particle_motion_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  pmu_pkg::t_in_item                   i_item,
    output logic                                o_valid,
    input  logic                                i_ready,
    output pmu_pkg::t_out_item                  o_item,
    input  logic                                i_cfg_we,
    input  logic [pmu_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pmu_pkg::CFG_W-1:0]           i_cfg_data
);

    pmu_pkg::t_cfg            r_cfg;
    logic [pmu_pkg::LAT-1:0]  r_vld;
    logic                     w_en;
    pmu_pkg::t_kin_res        w_kin;
    logic signed [pmu_pkg::LIFE_W-1:0] w_life;
    logic [pmu_pkg::Q16_W-1:0] w_alpha;
    logic                     w_alive;
    logic [pmu_pkg::Q16_W-1:0] w_size;

    assign w_en    = !r_vld[pmu_pkg::LAT-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[pmu_pkg::LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld               <= '0;
            r_cfg.gravity       <= pmu_pkg::GRAVITY_RST;
            r_cfg.drag_factor   <= pmu_pkg::DRAG_RST;
            r_cfg.pulse_rate    <= pmu_pkg::RATE_RST;
            r_cfg.pulse_depth   <= pmu_pkg::DEPTH_RST;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[pmu_pkg::LAT-2:0], i_valid};
            end
            if (i_cfg_we) begin
                unique case (pmu_pkg::t_reg_idx'(i_cfg_idx))
                    pmu_pkg::REG_GRAVITY: r_cfg.gravity     <= i_cfg_data;
                    pmu_pkg::REG_DRAG:    r_cfg.drag_factor <= i_cfg_data[15:0];
                    pmu_pkg::REG_RATE:    r_cfg.pulse_rate  <= i_cfg_data[15:0];
                    pmu_pkg::REG_DEPTH:   r_cfg.pulse_depth <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    pmu_kin u_kin (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_item (i_item),
        .i_cfg  (r_cfg),
        .o_res  (w_kin)
    );

    pmu_div u_div (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_item  (i_item),
        .o_life  (w_life),
        .o_alpha (w_alpha),
        .o_alive (w_alive)
    );

    pmu_pulse u_pulse (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_item (i_item),
        .i_cfg  (r_cfg),
        .o_size (w_size)
    );

    always_comb begin
        o_item.pos_x_out = w_kin.pos[0];
        o_item.pos_y_out = w_kin.pos[1];
        o_item.pos_z_out = w_kin.pos[2];
        o_item.vel_x_out = w_kin.vel[0];
        o_item.vel_y_out = w_kin.vel[1];
        o_item.vel_z_out = w_kin.vel[2];
        o_item.life_out  = w_life;
        o_item.alpha_out = w_alpha;
        o_item.size_out  = w_size;
        o_item.alive     = w_alive;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    pmu_pkg::t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    pmu_pkg::t_out_item o_item;
    logic      i_cfg_we;
    logic [pmu_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [pmu_pkg::CFG_W-1:0]     i_cfg_data;

    particle_motion_update uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    pmu_pkg::t_in_item  pending_words [$];
    pmu_pkg::t_out_item expected_words [$];
    logic signed [15:0] sine_tab [pmu_pkg::SINE_DEPTH];

    longint unsigned cur_gravity;
    longint unsigned cur_drag;
    longint unsigned cur_rate;
    longint unsigned cur_depth;

    int  mismatches;
    int  idle_cycles;
    int  send_gap;
    int  stall_left;
    bit  steady;
    bit  accepted_in;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned taylor(longint unsigned x, bit odd);
        longint unsigned x2, term, plus, minus, a;
        x2 = (x * x) >> 30;
        term = odd ? x : (64'd1 << 30);
        plus = term;
        minus = 0;
        for (int k = 1; k <= 10; k++) begin
            a = odd ? 2 * k : 2 * k - 1;
            term = ((term * x2) >> 30) / (a * (a + 1));
            if (k % 2 == 1) begin
                minus += term;
            end else begin
                plus += term;
            end
        end
        return (plus > minus) ? plus - minus : 0;
    endfunction

    function automatic longint rnd_shift(longint x, int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic pmu_pkg::t_out_item advance_particle(pmu_pkg::t_in_item w);
        pmu_pkg::t_out_item r;
        longint p[3], v[3], np, nv, dt, life, alpha, phase, idx, q, s, m1, m2, sz;
        dt = longint'(w.time_step);
        p[0] = w.pos_x_in; p[1] = w.pos_y_in; p[2] = w.pos_z_in;
        v[0] = w.vel_x_in; v[1] = w.vel_y_in; v[2] = w.vel_z_in;
        for (int j = 0; j < 3; j++) begin
            np = clamp(p[j] + rnd_shift(v[j] * dt, 16), -8388608, 8388607);
            nv = v[j];
            if (j == 1) begin
                nv -= rnd_shift(longint'(cur_gravity) * dt, 16);
            end
            nv = clamp(rnd_shift(nv * longint'(cur_drag), 16), -8388608, 8388607);
            p[j] = np;
            v[j] = nv;
        end
        life = clamp(longint'(w.life_in) - ((dt + 8) >> 4), -32768, 32767);
        alpha = longint'(w.alpha_in);
        if (life > 0) begin
            if (w.max_life == 0) begin
                alpha = 65535;
            end else begin
                alpha = clamp((life * 65536) / longint'(w.max_life), 0, 65535);
            end
        end
        phase = life * longint'(cur_rate);
        idx = phase * pmu_pkg::SINE_DEPTH;
        q = idx / 6588397;
        if (idx < 0 && q * 6588397 != idx) begin
            q -= 1;
        end
        q = q % pmu_pkg::SINE_DEPTH;
        if (q < 0) begin
            q += pmu_pkg::SINE_DEPTH;
        end
        s = sine_tab[q];
        m1 = rnd_shift(s * longint'(cur_depth), 16);
        m2 = rnd_shift(m1 * dt, 16);
        sz = longint'(w.size_in);
        sz = clamp(sz + rnd_shift(sz * m2, 15), 0, 65535);
        r.pos_x_out = p[0][23:0]; r.pos_y_out = p[1][23:0]; r.pos_z_out = p[2][23:0];
        r.vel_x_out = v[0][23:0]; r.vel_y_out = v[1][23:0]; r.vel_z_out = v[2][23:0];
        r.life_out  = life[15:0];
        r.alpha_out = alpha[15:0];
        r.size_out  = sz[15:0];
        r.alive     = (life > 0);
        return r;
    endfunction

    function automatic longint unsigned pick_bits(int w);
        longint unsigned m;
        m = (64'd1 << w) - 1;
        case ($urandom_range(0, 9))
            0: return m;
            1: return 0;
            2: return 64'd1 << (w - 1);
            3: return (64'd1 << (w - 1)) - 1;
            4: return $urandom_range(0, 3);
            default: return {$urandom, $urandom} & m;
        endcase
    endfunction

    function automatic pmu_pkg::t_in_item random_word();
        pmu_pkg::t_in_item w;
        longint unsigned b [11];
        for (int f = 0; f < 6; f++) begin
            b[f] = pick_bits(pmu_pkg::POS_W);
        end
        b[6]  = pick_bits(pmu_pkg::LIFE_W);
        b[7]  = pick_bits(pmu_pkg::MAXL_W);
        b[8]  = pick_bits(pmu_pkg::Q16_W);
        b[9]  = pick_bits(pmu_pkg::Q16_W);
        b[10] = pick_bits(pmu_pkg::Q16_W);
        w.pos_x_in  = b[0][pmu_pkg::POS_W-1:0];
        w.pos_y_in  = b[1][pmu_pkg::POS_W-1:0];
        w.pos_z_in  = b[2][pmu_pkg::POS_W-1:0];
        w.vel_x_in  = b[3][pmu_pkg::POS_W-1:0];
        w.vel_y_in  = b[4][pmu_pkg::POS_W-1:0];
        w.vel_z_in  = b[5][pmu_pkg::POS_W-1:0];
        w.life_in   = b[6][pmu_pkg::LIFE_W-1:0];
        w.max_life  = b[7][pmu_pkg::MAXL_W-1:0];
        w.alpha_in  = b[8][pmu_pkg::Q16_W-1:0];
        w.size_in   = b[9][pmu_pkg::Q16_W-1:0];
        w.time_step = b[10][pmu_pkg::Q16_W-1:0];
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    task automatic write_reg(pmu_pkg::t_reg_idx idx, longint unsigned value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[pmu_pkg::CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            pmu_pkg::REG_GRAVITY: cur_gravity = value & 64'h3FFFF;
            pmu_pkg::REG_DRAG:    cur_drag    = value & 64'hFFFF;
            pmu_pkg::REG_RATE:    cur_rate    = value & 64'hFFFF;
            pmu_pkg::REG_DEPTH:   cur_depth   = value & 64'hFFFF;
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || i_valid || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (pmu_pkg::LAT + 5) @(posedge i_clk);
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch %s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        accepted_in <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            expected_words.insert(expected_words.size(), advance_particle(i_item));
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected output word %h", o_item);
                end
            end else begin
                pmu_pkg::t_out_item e;
                e = expected_words.pop_front();
                check_field("pos_x", e.pos_x_out, o_item.pos_x_out);
                check_field("pos_y", e.pos_y_out, o_item.pos_y_out);
                check_field("pos_z", e.pos_z_out, o_item.pos_z_out);
                check_field("vel_x", e.vel_x_out, o_item.vel_x_out);
                check_field("vel_y", e.vel_y_out, o_item.vel_y_out);
                check_field("vel_z", e.vel_z_out, o_item.vel_z_out);
                check_field("life", e.life_out, o_item.life_out);
                check_field("alpha", e.alpha_out, o_item.alpha_out);
                check_field("size", e.size_out, o_item.size_out);
                check_field("alive", e.alive, o_item.alive);
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || accepted_in) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    i_item   <= pending_words.pop_front();
                    i_valid  <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready    <= 1'b0;
            end else begin
                i_ready    <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 5000) begin
            $display("** particle_motion_update: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        pmu_pkg::t_in_item w;
        longint unsigned qd, rm, xx, vv, ss;
        for (int i = 0; i < pmu_pkg::SINE_DEPTH; i++) begin
            qd = (4 * i) / pmu_pkg::SINE_DEPTH;
            rm = 4 * i - qd * pmu_pkg::SINE_DEPTH;
            xx = (rm * 64'd1686629713) / pmu_pkg::SINE_DEPTH;
            vv = taylor(xx, qd[0] == 1'b0);
            ss = (vv + (64'd1 << 14)) >> 15;
            if (ss > 32767) begin
                ss = 32767;
            end
            sine_tab[i] = (qd >= 2) ? -$signed(ss[15:0]) : $signed(ss[15:0]);
        end
        cur_gravity = 40182;
        cur_drag    = 64881;
        cur_rate    = 2560;
        cur_depth   = 6554;
        mismatches  = 0;
        idle_cycles = 0;
        send_gap    = 0;
        stall_left  = 0;
        steady      = 1'b0;
        accepted_in = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int d = 0; d < 16; d++) begin
            w = '0;
            w.max_life = 15'd4096;
            case (d)
                1: begin
                    w.pos_x_in = 24'h7FFFFF; w.pos_y_in = 24'h7FFFFF; w.pos_z_in = 24'h7FFFFF;
                    w.vel_x_in = 24'h7FFFFF; w.vel_y_in = 24'h7FFFFF; w.vel_z_in = 24'h7FFFFF;
                    w.time_step = 16'hFFFF; w.life_in = 16'sh7FFF;
                end
                2: begin
                    w.pos_x_in = 24'h800000; w.pos_y_in = 24'h800000; w.pos_z_in = 24'h800000;
                    w.vel_x_in = 24'h800000; w.vel_y_in = 24'h800000; w.vel_z_in = 24'h800000;
                    w.time_step = 16'hFFFF; w.life_in = 16'sh8000;
                end
                3: begin w.life_in = 16'sh1000; w.max_life = 15'd0; end
                4: begin w.life_in = -16'sd100; w.alpha_in = 16'hABCD; end
                5: begin w.life_in = 16'sd10; w.time_step = 16'd160; w.alpha_in = 16'h1234; end
                6: begin w.life_in = 16'sh7FFF; w.max_life = 15'd1; end
                7: begin w.life_in = 16'sh7FFF; w.max_life = 15'h7FFF; w.size_in = 16'hFFFF; end
                8: begin w.life_in = -16'sd3000; w.size_in = 16'hFFFF; w.time_step = 16'hFFFF; end
                9: begin w.life_in = 16'sd1; w.time_step = 16'd7; end
                10: begin w.life_in = 16'sd1; w.time_step = 16'd8; end
                11: begin w.alpha_in = 16'hFFFF; w.size_in = 16'h8000; w.life_in = 16'sd20000; end
                12: begin w = random_word(); w.life_in = -16'sd32768; end
                default: w = random_word();
            endcase
            pending_words.insert(pending_words.size(), w);
        end
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: begin
                    write_reg(pmu_pkg::REG_GRAVITY, 64'h3FFFF);
                    write_reg(pmu_pkg::REG_DRAG, 64'hFFFF);
                    write_reg(pmu_pkg::REG_RATE, 64'hFFFF);
                    write_reg(pmu_pkg::REG_DEPTH, 64'hFFFF);
                end
                2: begin
                    write_reg(pmu_pkg::REG_GRAVITY, 0);
                    write_reg(pmu_pkg::REG_DRAG, 0);
                    write_reg(pmu_pkg::REG_RATE, 0);
                    write_reg(pmu_pkg::REG_DEPTH, 0);
                end
                3, 4, 5: begin
                    write_reg(pmu_pkg::REG_GRAVITY, $urandom_range(0, 262143));
                    write_reg(pmu_pkg::REG_DRAG, $urandom_range(0, 65535));
                    write_reg(pmu_pkg::REG_RATE, $urandom_range(0, 65535));
                    write_reg(pmu_pkg::REG_DEPTH, $urandom_range(0, 65535));
                end
                default: ;
            endcase
            steady = (ph % 3 == 2);
            for (int n = 0; n < 215; n++) begin
                pending_words.insert(pending_words.size(), random_word());
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("** particle_motion_update: PASSED **");
        end else begin
            $display("** particle_motion_update: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pmu_pkg.sv
hw/rtl/pmu_kin.sv
hw/rtl/pmu_div.sv
hw/rtl/pmu_pulse.sv
hw/rtl/particle_motion_update.sv
tb/sv/tb.sv
